// ----- design/tilted_ellipse_arc_bound_core_defines.svh -----
// Assertion helpers shared by the arc bound core
`ifndef TILTED_ELLIPSE_ARC_BOUND_CORE_DEFINES_SVH
`define TILTED_ELLIPSE_ARC_BOUND_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TEAB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arc bound check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define TEAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arc bound check failed");

`endif

// ----- design/teab_pkg.sv -----
`timescale 1ns / 1ps

package teab_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_FRAC_DEF  = 16;

  // internal angles are Q30 radians
  localparam int IANG  = 30;
  localparam int STEPS = 30;
  localparam int ANG_W = 38;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic signed [ANG_W-1:0] PI_I     = ANG_W'((PI_Q60 + (64'd1 << 29)) >> 30);
  localparam logic signed [ANG_W-1:0] HALF_PI  = PI_I >>> 1;
  localparam logic signed [ANG_W-1:0] TWO_PI_I = PI_I <<< 1;

  // pre-scaled CORDIC start vector
  localparam logic signed [33:0] GAIN_I = 34'sd652032874;

  // pipeline depths of the two CORDIC units
  localparam int AT_LAT = STEPS + 4;
  localparam int SC_LAT = STEPS + 3;

  // round(atan(2^-i) * 2^30)
  localparam logic signed [ANG_W-1:0] ATAN_TAB [STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516,  16775851,  8388437,   4194283,   2097149,
    1048576,   524288,    262144,    131072,    65536,
    32768,     16384,     8192,      4096,      2048,
    1024,      512,       256,       128,       64,
    32,        16,        8,         4,         2
  };

  // fraction bits kept on sine and cosine
  function automatic int trig_frac(input int cw);
    return ((59 - cw) < 30) ? (59 - cw) : 30;
  endfunction

  // round(2pi * 2^af)
  function automatic logic [63:0] two_pi_a(input int af);
    return (PI_Q60 + (64'd1 << (58 - af))) >> (59 - af);
  endfunction

endpackage

// ----- design/teab_atan.sv -----
`timescale 1ns / 1ps

module teab_atan import teab_pkg::*; #(
  parameter int NW = COORD_WIDTH_DEF + 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [NW-1:0]    num,
  input  logic signed [NW-1:0]    den,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] angle
);

  localparam int DW = NW + 1;
  localparam int MW = $clog2(DW);
  localparam int XW = 44;
  localparam logic signed [XW-1:0] LIM = XW'(64'd1 << 40);

  typedef struct packed {
    logic zero;
    logic pos;
    logic neg;
  } spec_t;

  // stage 1: fold sign of the denominator, take the larger magnitude
  logic signed [DW-1:0] nn_c, dd_c;
  logic [DW-1:0]        am_c, m_c;
  logic                 v1;
  spec_t                sp1;
  logic signed [DW-1:0] nn1, dd1;
  logic [DW-1:0]        m1;

  always_comb begin
    nn_c = (den < 0) ? -DW'(num) : DW'(num);
    dd_c = (den < 0) ? -DW'(den) : DW'(den);
    am_c = (nn_c < 0) ? $unsigned(-nn_c) : $unsigned(nn_c);
    m_c  = (am_c > $unsigned(dd_c)) ? am_c : $unsigned(dd_c);
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    nn1 <= nn_c;
    dd1 <= dd_c;
    m1  <= m_c;
    sp1 <= '{zero: (den == '0), pos: (num > 0), neg: (num < 0)};
  end

  // stage 2: leading one of the magnitude
  logic [MW-1:0]        msb_c, msb2;
  logic                 v2;
  spec_t                sp2;
  logic signed [DW-1:0] nn2, dd2;

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < DW; i++) begin
      if (m1[i]) msb_c = MW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  always_ff @(posedge clk) begin
    msb2 <= msb_c;
    nn2  <= nn1;
    dd2  <= dd1;
    sp2  <= sp1;
  end

  // stage 3: bring the larger operand to bit 38 or 39
  logic signed [XW-1:0] rn_c, rd_c, rn3, rd3;
  logic                 v3;
  spec_t                sp3;

  always_comb begin
    rn_c = XW'(nn2);
    rd_c = XW'(dd2);
    if (int'(msb2) >= 40) begin
      rn_c = XW'(nn2 >>> (int'(msb2) - 39));
      rd_c = XW'(dd2 >>> (int'(msb2) - 39));
    end else if (int'(msb2) < 38) begin
      rn_c = XW'(nn2) <<< (38 - int'(msb2));
      rd_c = XW'(dd2) <<< (38 - int'(msb2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
  end

  always_ff @(posedge clk) begin
    rn3 <= rn_c;
    rd3 <= rd_c;
    sp3 <= sp2;
  end

  // stage 4: one more bit when floor rounding left the numerator at 2^40
  logic                 big;
  logic signed [XW-1:0] xq [STEPS+1];
  logic signed [XW-1:0] yq [STEPS+1];
  logic signed [ANG_W-1:0] zq [STEPS+1];
  logic                 vq [STEPS+1];
  spec_t                sq [STEPS+1];

  assign big = (rn3 >= LIM) || (rn3 <= -LIM);

  always_ff @(posedge clk) begin
    if (rst) vq[0] <= 1'b0;
    else vq[0] <= v3;
  end

  always_ff @(posedge clk) begin
    xq[0] <= big ? (rd3 >>> 1) : rd3;
    yq[0] <= big ? (rn3 >>> 1) : rn3;
    zq[0] <= '0;
    sq[0] <= sp3;
  end

  // vectoring rotations, one per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (rst) vq[i+1] <= 1'b0;
      else vq[i+1] <= vq[i];
    end

    always_ff @(posedge clk) begin
      sq[i+1] <= sq[i];
      if (yq[i] > 0) begin
        xq[i+1] <= xq[i] + (yq[i] >>> i);
        yq[i+1] <= yq[i] - (xq[i] >>> i);
        zq[i+1] <= zq[i] + ATAN_TAB[i];
      end else begin
        xq[i+1] <= xq[i] - (yq[i] >>> i);
        yq[i+1] <= yq[i] + (xq[i] >>> i);
        zq[i+1] <= zq[i] - ATAN_TAB[i];
      end
    end
  end

  // vertical slope or no slope
  always_comb begin
    angle = zq[STEPS];
    if (sq[STEPS].zero) begin
      if (sq[STEPS].pos) angle = HALF_PI;
      else if (sq[STEPS].neg) angle = -HALF_PI;
      else angle = '0;
    end
  end

  assign out_valid = vq[STEPS];

endmodule

// ----- design/teab_sincos.sv -----
`timescale 1ns / 1ps

module teab_sincos import teab_pkg::*; #(
  parameter int TF = 27
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] angle,
  output logic                    out_valid,
  output logic signed [TF+2:0]    cos_out,
  output logic signed [TF+2:0]    sin_out
);

  localparam int XW = 34;
  localparam int SH = IANG - TF;
  localparam logic signed [XW-1:0] RND = XW'((64'd1 << SH) >> 1);

  function automatic logic signed [ANG_W-1:0] wrap(input logic signed [ANG_W-1:0] t);
    if (t > PI_I) return t - TWO_PI_I;
    else if (t < -PI_I) return t + TWO_PI_I;
    else return t;
  endfunction

  // stage 1: bring the angle into [-pi, pi]
  logic                    v1;
  logic signed [ANG_W-1:0] t1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    t1 <= wrap(wrap(wrap(angle)));
  end

  // stage 2: fold into the right half plane
  logic signed [XW-1:0]    xq [STEPS+1];
  logic signed [XW-1:0]    yq [STEPS+1];
  logic signed [ANG_W-1:0] zq [STEPS+1];
  logic                    vq [STEPS+1];
  logic                    nq [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) vq[0] <= 1'b0;
    else vq[0] <= v1;
  end

  always_ff @(posedge clk) begin
    xq[0] <= XW'(GAIN_I);
    yq[0] <= '0;
    if (t1 > HALF_PI) begin
      zq[0] <= t1 - PI_I;
      nq[0] <= 1'b1;
    end else if (t1 < -HALF_PI) begin
      zq[0] <= t1 + PI_I;
      nq[0] <= 1'b1;
    end else begin
      zq[0] <= t1;
      nq[0] <= 1'b0;
    end
  end

  // rotation stages
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) vq[i+1] <= 1'b0;
      else vq[i+1] <= vq[i];
    end

    always_ff @(posedge clk) begin
      nq[i+1] <= nq[i];
      if (zq[i] >= 0) begin
        xq[i+1] <= xq[i] - (yq[i] >>> i);
        yq[i+1] <= yq[i] + (xq[i] >>> i);
        zq[i+1] <= zq[i] - ATAN_TAB[i];
      end else begin
        xq[i+1] <= xq[i] + (yq[i] >>> i);
        yq[i+1] <= yq[i] - (xq[i] >>> i);
        zq[i+1] <= zq[i] + ATAN_TAB[i];
      end
    end
  end

  // unfold and round half up to TF fraction bits
  logic signed [XW-1:0] xr, yr;

  assign xr = nq[STEPS] ? -xq[STEPS] : xq[STEPS];
  assign yr = nq[STEPS] ? -yq[STEPS] : yq[STEPS];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vq[STEPS];
  end

  always_ff @(posedge clk) begin
    cos_out <= (TF+3)'((xr + RND) >>> SH);
    sin_out <= (TF+3)'((yr + RND) >>> SH);
  end

endmodule

// ----- design/tilted_ellipse_arc_bound_core.sv -----
// An arc passes S0-S2, the atan units, S3, the sincos units, S4-S8; done marks it on the outputs.
// Throughput: one arc per cycle; busy is low whenever rst is low.
// The depth is set by two 30-step CORDIC pipelines in series (atan, then sine/cosine).
// Reset: rst (synchronous) clears every valid bit; in-flight arcs are dropped.
// The receiver cannot stall: done is a one-cycle strobe.
`timescale 1ns / 1ps
`include "tilted_ellipse_arc_bound_core_defines.svh"

module tilted_ellipse_arc_bound_core import teab_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  center_x,
  input  logic signed [COORD_WIDTH-1:0]  center_y,
  input  logic signed [COORD_WIDTH-1:0]  axis_x,
  input  logic signed [COORD_WIDTH-1:0]  axis_y,
  input  logic [18:0]                    ratio,
  input  logic signed [ANGLE_FRAC_BITS+3:0] start_angle,
  input  logic signed [ANGLE_FRAC_BITS+3:0] end_angle,
  input  logic                           ccw,
  output logic                           done,
  output logic signed [COORD_WIDTH-1:0]  min_x,
  output logic signed [COORD_WIDTH-1:0]  max_x,
  output logic signed [COORD_WIDTH-1:0]  min_y,
  output logic signed [COORD_WIDTH-1:0]  max_y,
  output logic signed [ANGLE_FRAC_BITS+4:0] norm_start,
  output logic signed [ANGLE_FRAC_BITS+4:0] norm_end
);

  localparam int CW  = COORD_WIDTH;
  localparam int AF  = ANGLE_FRAC_BITS;
  localparam int TF  = trig_frac(CW);
  localparam int AIW = AF + 4;
  localparam int AOW = AF + 5;
  localparam int NAW = AF + 7;
  localparam int BW  = CW + 4;
  localparam int NW  = CW + 5;
  localparam int TRW = TF + 3;
  localparam int PW  = CW + 20;
  localparam int PXW = CW + TRW;
  localparam int PBW = BW + TRW;
  localparam int VW  = CW + TF + 8;
  localparam int OW  = VW + 2;
  localparam int SCS = IANG - AF;
  localparam int TOT_LAT = 3 + AT_LAT + 1 + SC_LAT + 5;

  localparam logic signed [NAW-1:0]   TWA  = NAW'(two_pi_a(AF));
  localparam logic signed [ANG_W-1:0] TW_Q = ANG_W'(two_pi_a(AF) << SCS);
  localparam logic signed [PW-1:0]    RNDR = PW'(32768);
  localparam logic signed [OW-1:0]    RNDO = OW'(64'd1 << (TF - 1));
  localparam logic signed [OW-1:0]    MAXC = OW'(64'd1 << (CW - 1)) - OW'(1);
  localparam logic signed [OW-1:0]    MINC = -MAXC - OW'(1);

  typedef struct packed {
    logic signed [NAW-1:0] s_ang;
    logic signed [NAW-1:0] e_ang;
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [BW-1:0]  bax;
    logic signed [BW-1:0]  bay;
    logic [3:0]            hit;
  } side_t;

  function automatic logic in_span(input logic signed [ANG_W-1:0] t,
                                   input logic signed [ANG_W-1:0] lo,
                                   input logic signed [ANG_W-1:0] hi);
    return (t > lo && t < hi) || (t > lo + TW_Q && t < hi + TW_Q) ||
           (t > lo - TW_Q && t < hi - TW_Q);
  endfunction

  function automatic logic signed [VW-1:0] vmin(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [VW-1:0] vmax(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // add center, round half up, saturate
  function automatic logic signed [CW-1:0] to_coord(input logic signed [VW-1:0] v,
                                                    input logic signed [CW-1:0] c);
    logic signed [OW-1:0] acc;
    acc = OW'(v) + (OW'(c) <<< TF) + RNDO;
    acc = acc >>> TF;
    if (acc > MAXC) acc = MAXC;
    if (acc < MINC) acc = MINC;
    return CW'(acc);
  endfunction

  assign busy = rst;

  // S0: input register
  logic                  v0;
  logic signed [CW-1:0]  cx0, cy0, ax0, ay0;
  logic [18:0]           r0;
  logic signed [AIW-1:0] sa0, ea0;
  logic                  ccw0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start && !busy;
  end

  always_ff @(posedge clk) begin
    cx0  <= center_x;
    cy0  <= center_y;
    ax0  <= axis_x;
    ay0  <= axis_y;
    r0   <= ratio;
    sa0  <= start_angle;
    ea0  <= end_angle;
    ccw0 <= ccw;
  end

  // S1: span normalization and ratio products
  logic signed [NAW-1:0] s_c, e_c, s1, e1;
  logic signed [PW-1:0]  pax1, pay1;
  logic signed [CW-1:0]  cx1, cy1, ax1, ay1;
  logic                  v1;

  always_comb begin
    s_c = NAW'(sa0);
    e_c = NAW'(ea0);
    if (ccw0) begin
      if (e_c - s_c <= 0) e_c = e_c + TWA;
    end else if (e_c - s_c > 0) begin
      e_c = e_c - TWA;
    end
    if (s_c >= TWA || e_c >= TWA) begin
      s_c = s_c - TWA;
      e_c = e_c - TWA;
    end else if (s_c < -TWA || e_c < -TWA) begin
      s_c = s_c + TWA;
      e_c = e_c + TWA;
    end
    if (s_c < 0 && e_c < 0) begin
      s_c = s_c + TWA;
      e_c = e_c + TWA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
  end

  always_ff @(posedge clk) begin
    s1   <= s_c;
    e1   <= e_c;
    pax1 <= ax0 * $signed({1'b0, r0});
    pay1 <= ay0 * $signed({1'b0, r0});
    cx1  <= cx0;
    cy1  <= cy0;
    ax1  <= ax0;
    ay1  <= ay0;
  end

  // S2: round the scaled minor axis
  side_t sd2;
  logic  v2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
  end

  always_ff @(posedge clk) begin
    sd2 <= '{s_ang: s1, e_ang: e1, ax: ax1, ay: ay1, cx: cx1, cy: cy1,
             bax: BW'((pax1 + RNDR) >>> 16), bay: BW'((pay1 + RNDR) >>> 16),
             hit: 4'b0000};
  end

  // extremum parameters
  logic                    atx_v, aty_v;
  logic signed [ANG_W-1:0] atx, aty;

  teab_atan #(.NW(NW)) u_atan_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .num       (-NW'(sd2.bay)),
    .den       (NW'(sd2.ax)),
    .out_valid (atx_v),
    .angle     (atx)
  );

  teab_atan #(.NW(NW)) u_atan_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .num       (NW'(sd2.bax)),
    .den       (NW'(sd2.ay)),
    .out_valid (aty_v),
    .angle     (aty)
  );

  side_t dly_a [AT_LAT];

  always_ff @(posedge clk) begin
    dly_a[0] <= sd2;
    for (int i = 1; i < AT_LAT; i++) dly_a[i] <= dly_a[i-1];
  end

  // S3: span tests on the four extremum candidates
  side_t                   sda, sdh_c, sd3;
  logic signed [ANG_W-1:0] ts_c, te_c, lo_c, hi_c, tx1_c, ty1_c;
  logic signed [ANG_W-1:0] ang3 [6];
  logic                    v3;

  assign sda   = dly_a[AT_LAT-1];
  assign ts_c  = ANG_W'(sda.s_ang) <<< SCS;
  assign te_c  = ANG_W'(sda.e_ang) <<< SCS;
  assign lo_c  = (ts_c < te_c) ? ts_c : te_c;
  assign hi_c  = (ts_c < te_c) ? te_c : ts_c;
  assign tx1_c = atx + PI_I;
  assign ty1_c = aty + PI_I;

  always_comb begin
    sdh_c     = sda;
    sdh_c.hit = {in_span(ty1_c, lo_c, hi_c), in_span(aty, lo_c, hi_c),
                 in_span(tx1_c, lo_c, hi_c), in_span(atx, lo_c, hi_c)};
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= atx_v;
  end

  always_ff @(posedge clk) begin
    sd3     <= sdh_c;
    ang3[0] <= ts_c;
    ang3[1] <= te_c;
    ang3[2] <= atx;
    ang3[3] <= tx1_c;
    ang3[4] <= aty;
    ang3[5] <= ty1_c;
  end

  // sine and cosine at both end points and every candidate
  logic                  sc_v [6];
  logic signed [TRW-1:0] cs [6];
  logic signed [TRW-1:0] sn [6];

  for (genvar k = 0; k < 6; k++) begin : g_sc
    teab_sincos #(.TF(TF)) u_sc (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v3),
      .angle     (ang3[k]),
      .out_valid (sc_v[k]),
      .cos_out   (cs[k]),
      .sin_out   (sn[k])
    );
  end

  side_t dly_b [SC_LAT];

  always_ff @(posedge clk) begin
    dly_b[0] <= sd3;
    for (int i = 1; i < SC_LAT; i++) dly_b[i] <= dly_b[i-1];
  end

  // S4: products; x uses the end points and x candidates, y the end points and y candidates
  side_t                 sdb, sd4;
  logic signed [PXW-1:0] pxc [4];
  logic signed [PBW-1:0] pxs [4];
  logic signed [PXW-1:0] pyc [4];
  logic signed [PBW-1:0] pys [4];
  logic                  v4;

  assign sdb = dly_b[SC_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= sc_v[0];
  end

  always_ff @(posedge clk) begin
    sd4 <= sdb;
  end

  for (genvar j = 0; j < 4; j++) begin : g_mul
    localparam int YI = (j < 2) ? j : j + 2;
    always_ff @(posedge clk) begin
      pxc[j] <= sdb.ax * cs[j];
      pxs[j] <= sdb.bay * sn[j];
      pyc[j] <= sdb.ay * cs[YI];
      pys[j] <= sdb.bax * sn[YI];
    end
  end

  // S5: coordinates; a candidate outside the span repeats the start point
  side_t                sd5;
  logic signed [VW-1:0] vx_c [4];
  logic signed [VW-1:0] vy_c [4];
  logic signed [VW-1:0] vx5 [4];
  logic signed [VW-1:0] vy5 [4];
  logic                 v5;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      vx_c[j] = VW'(pxc[j]) - VW'(pxs[j]);
      vy_c[j] = VW'(pys[j]) + VW'(pyc[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
  end

  always_ff @(posedge clk) begin
    sd5    <= sd4;
    vx5[0] <= vx_c[0];
    vx5[1] <= vx_c[1];
    vx5[2] <= sd4.hit[0] ? vx_c[2] : vx_c[0];
    vx5[3] <= sd4.hit[1] ? vx_c[3] : vx_c[0];
    vy5[0] <= vy_c[0];
    vy5[1] <= vy_c[1];
    vy5[2] <= sd4.hit[2] ? vy_c[2] : vy_c[0];
    vy5[3] <= sd4.hit[3] ? vy_c[3] : vy_c[0];
  end

  // S6: pairwise min and max
  side_t                sd6;
  logic signed [VW-1:0] mnx6 [2];
  logic signed [VW-1:0] mxx6 [2];
  logic signed [VW-1:0] mny6 [2];
  logic signed [VW-1:0] mxy6 [2];
  logic                 v6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
  end

  always_ff @(posedge clk) begin
    sd6 <= sd5;
    for (int p = 0; p < 2; p++) begin
      mnx6[p] <= vmin(vx5[2*p], vx5[2*p+1]);
      mxx6[p] <= vmax(vx5[2*p], vx5[2*p+1]);
      mny6[p] <= vmin(vy5[2*p], vy5[2*p+1]);
      mxy6[p] <= vmax(vy5[2*p], vy5[2*p+1]);
    end
  end

  // S7: final min and max
  side_t                sd7;
  logic signed [VW-1:0] mnx7, mxx7, mny7, mxy7;
  logic                 v7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else v7 <= v6;
  end

  always_ff @(posedge clk) begin
    sd7  <= sd6;
    mnx7 <= vmin(mnx6[0], mnx6[1]);
    mxx7 <= vmax(mxx6[0], mxx6[1]);
    mny7 <= vmin(mny6[0], mny6[1]);
    mxy7 <= vmax(mxy6[0], mxy6[1]);
  end

  // S8: output word
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v7;
  end

  always_ff @(posedge clk) begin
    min_x      <= to_coord(mnx7, sd7.cx);
    max_x      <= to_coord(mxx7, sd7.cx);
    min_y      <= to_coord(mny7, sd7.cy);
    max_y      <= to_coord(mxy7, sd7.cy);
    norm_start <= AOW'(sd7.s_ang);
    norm_end   <= AOW'(sd7.e_ang);
  end

  // checks
  `TEAB_ASSERT_SAME(a_box_order, done, (min_x <= max_x) && (min_y <= max_y))
  `TEAB_ASSERT_SAME(a_fixed_latency, done, $past(start && !busy, TOT_LAT))
  `TEAB_ASSERT_SAME(a_atan_aligned, atx_v || aty_v, atx_v && aty_v)
  `TEAB_ASSERT_SAME(a_sincos_aligned, sc_v[0] || sc_v[5], sc_v[0] && sc_v[3] && sc_v[5])
  `TEAB_ASSERT_NEXT(a_atan_to_sincos, atx_v, v3)

endmodule
